>>> hdl/lea_pkg.sv
// LEA cipher package: constants, register indexes and word helpers.
package lea_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned HalfWidth = 64;
   localparam int unsigned KeyWords  = 8;
   localparam int unsigned RkWords   = 6;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [HalfWidth-1:0] half_type;
   typedef logic [4:0]           round_type;
   typedef logic [2:0]           csr_index_type;
   typedef logic [1:0]           key_mode_type;

   localparam csr_index_type CsrKeyMode = 3'd0;
   localparam csr_index_type CsrKey01   = 3'd1;
   localparam csr_index_type CsrKey23   = 3'd2;
   localparam csr_index_type CsrKey45   = 3'd3;
   localparam csr_index_type CsrKey67   = 3'd4;

   localparam key_mode_type Mode128      = 2'd0;
   localparam key_mode_type Mode192      = 2'd1;
   localparam key_mode_type Mode256      = 2'd2;
   localparam key_mode_type ModeReserved = 2'd3;

   localparam round_type LastRound128 = round_type'(24 - 1);
   localparam round_type LastRound192 = round_type'(28 - 1);
   localparam round_type LastRound256 = round_type'(32 - 1);

   localparam word_type Delta [KeyWords] = '{
      32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
      32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
   };

   localparam logic [4:0] KeyRot [RkWords] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

   function automatic word_type rotl32(input word_type v, input logic [4:0] n);
      logic [2*WordWidth-1:0] w;
      begin
         w = {v, v} << n;
         return w[2*WordWidth-1:WordWidth];
      end
   endfunction

   function automatic word_type bswap32(input word_type a);
      return {a[7:0], a[15:8], a[23:16], a[31:24]};
   endfunction

endpackage

>>> hdl/lea_block_encrypt.sv
// LEA block encryption top level: key storage, round sequencer and round datapath.
//
// Usage: write key_mode and the four key word pairs through the csr_ port
// (index 0 mode, 1..4 key words) while the block is idle; writes take effect
// at once, indexes above 4 are ignored.
// A request is taken at a clock edge with start high and busy low; the
// plaintext is sampled from req_plain_high/req_plain_low at that edge.
// One round of key schedule plus round function runs per cycle, for 24,
// 28 or 32 rounds with a 128, 192 or 256 bit key, and the result is registered
// at the end of the last round. rsp_valid is high for exactly one cycle with
// rsp_cipher_high/rsp_cipher_low; the receiver cannot hold it off.
// busy drops in the result cycle, so a new request can be taken at the edge
// that ends it; the single round unit takes no new block while one runs.
// Reset clears the key registers and mode to zero and returns to idle;
// a block in flight is dropped.
module lea_block_encrypt (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lea_pkg::half_type req_plain_high,
   input  lea_pkg::half_type req_plain_low,
   output logic              rsp_valid,
   output lea_pkg::half_type rsp_cipher_high,
   output lea_pkg::half_type rsp_cipher_low,
   input  logic              csr_write_enable,
   input  lea_pkg::csr_index_type csr_index,
   input  lea_pkg::half_type csr_write_data
);
   import lea_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type    state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   round_type    round_ff, round_in;
   logic [2:0]   didx_ff, didx_in;
   key_mode_type key_mode_ff;
   half_type     key_ff [4];
   word_type     t_ff [KeyWords];
   word_type     t_in [KeyWords];
   word_type     x_ff [4];
   word_type     x_in [4];

   logic       m256, m192;
   round_type  last_round;
   logic [2:0] last_didx;
   word_type   dr;
   word_type   nk [RkWords];
   word_type   rk [RkWords];
   logic       accept;

   assign m256       = key_mode_ff[1];
   assign m192       = (key_mode_ff == Mode192);
   assign last_round = m256 ? LastRound256 : (m192 ? LastRound192 : LastRound128);
   assign last_didx  = m256 ? 3'd7 : (m192 ? 3'd5 : 3'd3);
   assign accept     = start && (state_ff == ST_IDLE);

   // key schedule: one rotated delta, fixed extra rotations per word
   assign dr = rotl32(Delta[didx_ff], round_ff);

   always_comb begin
      for (int j = 0; j < RkWords; j++) begin
         nk[j] = rotl32(t_ff[j] + rotl32(dr, 5'(j)), KeyRot[j]);
      end
      if (m256 || m192) begin
         for (int j = 0; j < RkWords; j++) begin
            rk[j] = nk[j];
         end
      end else begin
         rk[0] = nk[0];
         rk[1] = nk[1];
         rk[2] = nk[2];
         rk[3] = nk[1];
         rk[4] = nk[3];
         rk[5] = nk[1];
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      round_in     = round_ff;
      didx_in      = didx_ff;
      t_in         = t_ff;
      x_in         = x_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               round_in = '0;
               didx_in  = '0;
               for (int j = 0; j < 4; j++) begin
                  t_in[2*j]   = bswap32(key_ff[j][HalfWidth-1:WordWidth]);
                  t_in[2*j+1] = bswap32(key_ff[j][WordWidth-1:0]);
               end
               x_in[0] = bswap32(req_plain_high[HalfWidth-1:WordWidth]);
               x_in[1] = bswap32(req_plain_high[WordWidth-1:0]);
               x_in[2] = bswap32(req_plain_low[HalfWidth-1:WordWidth]);
               x_in[3] = bswap32(req_plain_low[WordWidth-1:0]);
            end
         end
         ST_RUN: begin
            // 256-bit mode rotates the key file so the next six words sit at 0..5
            if (m256) begin
               t_in[0] = t_ff[6];
               t_in[1] = t_ff[7];
               for (int j = 0; j < RkWords; j++) begin
                  t_in[j+2] = nk[j];
               end
            end else if (m192) begin
               for (int j = 0; j < RkWords; j++) begin
                  t_in[j] = nk[j];
               end
            end else begin
               for (int j = 0; j < 4; j++) begin
                  t_in[j] = nk[j];
               end
            end
            x_in[0] = rotl32((x_ff[0] ^ rk[0]) + (x_ff[1] ^ rk[1]), 5'd9);
            x_in[1] = rotl32((x_ff[1] ^ rk[2]) + (x_ff[2] ^ rk[3]), 5'd27);
            x_in[2] = rotl32((x_ff[2] ^ rk[4]) + (x_ff[3] ^ rk[5]), 5'd29);
            x_in[3] = x_ff[0];
            round_in = round_ff + 5'd1;
            didx_in  = (didx_ff == last_didx) ? 3'd0 : didx_ff + 3'd1;
            if (round_ff == last_round) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
         didx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         round_ff     <= round_in;
         didx_ff      <= didx_in;
      end
      t_ff <= t_in;
      x_ff <= x_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= '0;
         for (int j = 0; j < 4; j++) begin
            key_ff[j] <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrKeyMode: key_mode_ff <= csr_write_data[1:0];
            CsrKey01:   key_ff[0]   <= csr_write_data;
            CsrKey23:   key_ff[1]   <= csr_write_data;
            CsrKey45:   key_ff[2]   <= csr_write_data;
            CsrKey67:   key_ff[3]   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy            = (state_ff == ST_RUN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_high = {bswap32(x_ff[0]), bswap32(x_ff[1])};
   assign rsp_cipher_low  = {bswap32(x_ff[2]), bswap32(x_ff[3])};

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy) && $past(round_ff) == $past(last_round))
      else $error("result strobe outside the final round");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> round_ff <= last_round && didx_ff <= last_didx)
      else $error("round or delta counter out of range");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule
